// ===== design/clcg_pkg.sv =====
`default_nettype none

package clcg_pkg;

  // generator constants
  localparam logic [63:0] MUL64 = 64'd2147001325;
  localparam logic [63:0] ADD64 = 64'd715136305;
  localparam logic [31:0] MUL32 = 32'd1579544716;
  localparam logic [30:0] MOD31 = 31'h7fff_ffff;

  // request codes on the input word
  typedef enum logic [1:0] {
    REQ_SEED     = 2'd0,
    REQ_GEN      = 2'd1,
    REQ_SEEK_FWD = 2'd2,
    REQ_SEEK_BWD = 2'd3
  } req_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SEED,
    ST_SETUP,
    ST_GEN_BIG,
    ST_GEN_SMALL,
    ST_J64_VAL,
    ST_J64_ADD,
    ST_J64_SQR,
    ST_J31_VAL,
    ST_J31_ADD,
    ST_J31_SQR,
    ST_J31_FIN
  } state_e;

  // operand set and destination of one multiply-add
  typedef enum logic [2:0] {
    OP_GEN,
    OP_VAL64,
    OP_ADD64,
    OP_SQR64,
    OP_VAL31,
    OP_ADD31,
    OP_SQR31,
    OP_SMALL
  } opsel_e;

  // which 32x32 partial product
  typedef enum logic [1:0] {
    PP_LL,
    PP_LH,
    PP_HL
  } part_e;

  // controller to datapath
  typedef struct packed {
    logic   load;
    logic   prep;
    logic   seed;
    logic   setup;
    logic   backward;
    opsel_e opsel;
    logic   mul_en;
    part_e  part;
    logic   acc_init;
    logic   acc_add;
    logic   wb;
    logic   shift64;
    logic   shift31;
    logic   fin31;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic d64_lsb;
    logic d64_last;
    logic d31_lsb;
    logic d31_last;
    logic skip31;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/clcg_dpath.sv =====
`default_nettype none

module clcg_dpath import clcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [63:0] operand_value_i,
  output stat_t       stat_o,
  output logic [31:0] random_word_o
);

  // reduce a value below 3*2^31 modulo 2^31-1
  function automatic logic [30:0] red31(input logic [32:0] s);
    logic [31:0] f;
    f = {1'b0, s[30:0]} + {30'd0, s[32:31]};
    if (f >= {1'b0, MOD31}) begin
      f = f - {1'b0, MOD31};
    end
    return f[30:0];
  endfunction

  logic [63:0] big_q, big_d;
  logic [31:0] small_q, small_d;
  logic [63:0] op_q, op_d;
  logic [32:0] fold_q, fold_d;
  logic [63:0] dist64_q, dist64_d;
  logic [63:0] m64_q, m64_d;
  logic [63:0] a64_q, a64_d;
  logic [30:0] dist31_q, dist31_d;
  logic [30:0] v31_q, v31_d;
  logic [30:0] m31_q, m31_d;
  logic [30:0] a31_q, a31_d;
  logic        skip31_q, skip31_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] word_q, word_d;

  logic [63:0] x, y, z;
  logic [31:0] ma, mb;
  logic [63:0] mul_out;
  logic [63:0] res64;
  logic [30:0] res31;
  logic [31:0] snew;
  logic [31:0] word_sum;
  logic [30:0] op_mod;
  logic [30:0] seed_hi;
  logic [31:0] seed_small;

  // operand select per multiply-add
  always_comb begin
    x = '0;
    y = '0;
    z = '0;
    unique case (cmd_i.opsel)
      OP_GEN: begin
        x = big_q;
        y = MUL64;
        z = ADD64;
      end
      OP_VAL64: begin
        x = big_q;
        y = m64_q;
        z = a64_q;
      end
      OP_ADD64: begin
        x = a64_q;
        y = m64_q;
        z = a64_q;
      end
      OP_SQR64: begin
        x = m64_q;
        y = m64_q;
      end
      OP_VAL31: begin
        x = {33'd0, v31_q};
        y = {33'd0, m31_q};
        z = {33'd0, a31_q};
      end
      OP_ADD31: begin
        x = {33'd0, a31_q};
        y = {33'd0, m31_q};
        z = {33'd0, a31_q};
      end
      OP_SQR31: begin
        x = {33'd0, m31_q};
        y = {33'd0, m31_q};
      end
      OP_SMALL: begin
        x = {32'd0, small_q};
        y = {32'd0, MUL32};
      end
    endcase
  end

  // shared 32x32 multiplier
  always_comb begin
    case (cmd_i.part)
      PP_LH: begin
        ma = x[31:0];
        mb = y[63:32];
      end
      PP_HL: begin
        ma = x[63:32];
        mb = y[31:0];
      end
      default: begin
        ma = x[31:0];
        mb = y[31:0];
      end
    endcase
  end

  assign mul_out = {32'd0, ma} * {32'd0, mb};

  // results built from the registered product
  assign res64    = acc_q + {prod_q[31:0], 32'd0};
  assign res31    = red31({2'b00, prod_q[30:0]} + {2'b00, prod_q[61:31]} + {2'b00, z[30:0]});
  assign snew     = {1'b0, prod_q[30:0]} + {1'b0, prod_q[63:33]} + 32'd1;
  assign word_sum = big_q[63:32] + snew;

  // operand modulo 2^31-1 from the folded sum
  assign op_mod     = red31(fold_q);
  assign seed_hi    = op_q[62:32];
  assign seed_small = (seed_hi != MOD31) ? {1'b0, seed_hi} : {1'b0, op_mod};

  // next state of all datapath registers
  always_comb begin
    big_d    = big_q;
    small_d  = small_q;
    op_d     = op_q;
    fold_d   = fold_q;
    dist64_d = dist64_q;
    m64_d    = m64_q;
    a64_d    = a64_q;
    dist31_d = dist31_q;
    v31_d    = v31_q;
    m31_d    = m31_q;
    a31_d    = a31_q;
    skip31_d = skip31_q;
    prod_d   = prod_q;
    acc_d    = acc_q;
    word_d   = word_q;

    if (cmd_i.load) begin
      op_d = operand_value_i;
    end

    // 2^31 is 1 modulo 2^31-1, so the 31-bit chunks just add up
    if (cmd_i.prep) begin
      fold_d = {2'b00, op_q[30:0]} + {2'b00, op_q[61:31]} + {31'd0, op_q[63:62]};
    end

    if (cmd_i.seed) begin
      big_d   = op_q;
      small_d = seed_small;
    end

    // seek setup: jump distances and starting coefficients
    if (cmd_i.setup) begin
      m64_d = MUL64;
      a64_d = ADD64;
      v31_d = red31({1'b0, small_q});
      m31_d = MUL32[30:0];
      a31_d = 31'd1;
      if (cmd_i.backward) begin
        dist64_d = 64'd0 - op_q;
        dist31_d = (op_mod == 31'd0) ? 31'd0 : MOD31 - op_mod;
        skip31_d = (op_q == {33'd0, MOD31});
      end else begin
        dist64_d = op_q;
        dist31_d = op_mod;
        skip31_d = 1'b0;
      end
    end

    if (cmd_i.mul_en) begin
      prod_d = mul_out;
    end

    if (cmd_i.acc_init) begin
      acc_d = prod_q + z;
    end else if (cmd_i.acc_add) begin
      acc_d = acc_q + {prod_q[31:0], 32'd0};
    end

    if (cmd_i.shift64) begin
      dist64_d = {1'b0, dist64_q[63:1]};
    end
    if (cmd_i.shift31) begin
      dist31_d = {1'b0, dist31_q[30:1]};
    end

    if (cmd_i.fin31) begin
      small_d = {1'b0, v31_q};
    end

    // write back the finished multiply-add
    if (cmd_i.wb) begin
      unique case (cmd_i.opsel) inside
        OP_GEN, OP_VAL64: big_d = res64;
        OP_ADD64:         a64_d = res64;
        OP_SQR64:         m64_d = res64;
        OP_VAL31:         v31_d = res31;
        OP_ADD31:         a31_d = res31;
        OP_SQR31:         m31_d = res31;
        OP_SMALL: begin
          small_d = snew;
          word_d  = word_sum;
        end
      endcase
    end
  end

  // generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_q   <= '0;
      small_q <= '0;
    end else begin
      big_q   <= big_d;
      small_q <= small_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    fold_q   <= fold_d;
    dist64_q <= dist64_d;
    m64_q    <= m64_d;
    a64_q    <= a64_d;
    dist31_q <= dist31_d;
    v31_q    <= v31_d;
    m31_q    <= m31_d;
    a31_q    <= a31_d;
    skip31_q <= skip31_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    word_q   <= word_d;
  end

  // status for the controller
  assign stat_o.d64_lsb  = dist64_q[0];
  assign stat_o.d64_last = (dist64_q[63:1] == 63'd0);
  assign stat_o.d31_lsb  = dist31_q[0];
  assign stat_o.d31_last = (dist31_q[30:1] == 30'd0);
  assign stat_o.skip31   = skip31_q;

  assign random_word_o = word_q;

endmodule

`default_nettype wire

// ===== design/clcg_ctrl.sv =====
`default_nettype none

module clcg_ctrl import clcg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] req_type_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] ph_q, ph_d;
  req_e       req_q, req_d;
  logic       out_valid_q, out_valid_d;

  logic       is64;
  logic       done;
  logic       run;
  logic       out_free;
  logic       in_ready;
  cmd_t       cmd;

  // state, phase, request and output flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= '0;
      req_q       <= REQ_SEED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      req_q       <= req_d;
      out_valid_q <= out_valid_d;
    end
  end

  // 64-bit products take four phases, all others two
  assign is64 = (state_q == ST_GEN_BIG) || (state_q == ST_J64_VAL) ||
                (state_q == ST_J64_ADD) || (state_q == ST_J64_SQR);
  assign done = (ph_q == (is64 ? 2'd3 : 2'd1));
  assign out_free = ~out_valid_q | out_ready_i;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    req_d       = req_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd         = '0;
    in_ready    = 1'b0;
    run         = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          cmd.load = 1'b1;
          req_d    = req_e'(req_type_i);
          state_d  = (req_e'(req_type_i) == REQ_GEN) ? ST_GEN_BIG : ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        state_d  = (req_q == REQ_SEED) ? ST_SEED : ST_SETUP;
      end
      ST_SEED: begin
        cmd.seed = 1'b1;
        state_d  = ST_IDLE;
      end
      ST_SETUP: begin
        cmd.setup    = 1'b1;
        cmd.backward = (req_q == REQ_SEEK_BWD);
        state_d      = ST_J64_VAL;
      end
      ST_GEN_BIG: begin
        cmd.opsel = OP_GEN;
        run       = 1'b1;
        if (done) begin
          cmd.wb  = 1'b1;
          state_d = ST_GEN_SMALL;
        end
      end
      ST_GEN_SMALL: begin
        cmd.opsel = OP_SMALL;
        run       = 1'b1;
        // the word lands only once the output register is free
        if (done && out_free) begin
          cmd.wb      = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_J64_VAL: begin
        cmd.opsel = OP_VAL64;
        run       = stat_i.d64_lsb;
        if (!stat_i.d64_lsb || done) begin
          cmd.wb      = stat_i.d64_lsb;
          cmd.shift64 = 1'b1;
          if (!stat_i.d64_last) begin
            state_d = ST_J64_ADD;
          end else if (stat_i.skip31) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_J31_VAL;
          end
        end
      end
      ST_J64_ADD: begin
        cmd.opsel = OP_ADD64;
        run       = 1'b1;
        if (done) begin
          cmd.wb  = 1'b1;
          state_d = ST_J64_SQR;
        end
      end
      ST_J64_SQR: begin
        cmd.opsel = OP_SQR64;
        run       = 1'b1;
        if (done) begin
          cmd.wb  = 1'b1;
          state_d = ST_J64_VAL;
        end
      end
      ST_J31_VAL: begin
        cmd.opsel = OP_VAL31;
        run       = stat_i.d31_lsb;
        if (!stat_i.d31_lsb || done) begin
          cmd.wb      = stat_i.d31_lsb;
          cmd.shift31 = 1'b1;
          state_d     = stat_i.d31_last ? ST_J31_FIN : ST_J31_ADD;
        end
      end
      ST_J31_ADD: begin
        cmd.opsel = OP_ADD31;
        run       = 1'b1;
        if (done) begin
          cmd.wb  = 1'b1;
          state_d = ST_J31_SQR;
        end
      end
      ST_J31_SQR: begin
        cmd.opsel = OP_SQR31;
        run       = 1'b1;
        if (done) begin
          cmd.wb  = 1'b1;
          state_d = ST_J31_VAL;
        end
      end
      ST_J31_FIN: begin
        cmd.fin31 = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // partial products and phase count of a running multiply-add
    if (run) begin
      case (ph_q)
        2'd0: begin
          cmd.mul_en = 1'b1;
          cmd.part   = PP_LL;
        end
        2'd1: begin
          if (is64) begin
            cmd.mul_en   = 1'b1;
            cmd.part     = PP_LH;
            cmd.acc_init = 1'b1;
          end
        end
        2'd2: begin
          cmd.mul_en  = 1'b1;
          cmd.part    = PP_HL;
          cmd.acc_add = 1'b1;
        end
        default: ;
      endcase
      if (state_d != state_q) begin
        ph_d = '0;
      end else if (!done) begin
        ph_d = ph_q + 2'd1;
      end
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

`default_nettype wire

// ===== design/combined_lcg96_prng_with_seek_core.sv =====
// Combined 96-bit LCG random generator with seek.
// Input channel (in_valid_i/in_ready_o) carries one word: req_type_i and
// operand_value_i. Seed loads both generator states from operand_value_i,
// generate advances them and returns one random_word_o, seek forward and
// seek backward jump both states by operand_value_i steps.
// Only generate returns a word, on the output channel (out_valid_o/out_ready_i).
// Steps of each request, all products on one shared 32x32 multiplier:
//   generate: a 64-bit multiply-add on the 64-bit state, then a 32-bit one
//   seed: operand fold, then load of both states
//   seek: fold and setup, then per bit of the 64-bit distance a multiply-add
//   into the state if the bit is set, then add and square steps, and the same
//   per bit of the 31-bit distance; the top bit of each skips add and square,
//   plus one closing step for the 31-bit jump
// in_ready_o is high only while no word is in work.
// The result sits in an output register: while the receiver stalls, the block
// keeps taking seeds and seeks; a generate then waits at its last step until
// the output register is taken.
// Reset clears both generator states to zero and drops out_valid_o.
`default_nettype none

module combined_lcg96_prng_with_seek_core import clcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] operand_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] random_word_o
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  clcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (req_type_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // state, jump registers and multiplier
  clcg_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .operand_value_i (operand_value_i),
    .stat_o          (stat),
    .random_word_o   (random_word_o)
  );

`ifndef SYNTHESIS
  // an accepted word always leaves the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input still ready right after an accepted word");

  // a new word appears only as the generate finishes and the block goes idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("output word raised while busy");

  // seed and seek requests never raise an output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (req_e'(req_type_i) != REQ_GEN)) |=> !$rose(out_valid_o))
    else $error("output word after a seed or seek request");

  // the datapath never writes back and starts a product in the same step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wb |-> !cmd.mul_en)
    else $error("write back overlaps a multiply");
`endif

endmodule

`default_nettype wire
